@@ hdl/hsvrgb_pkg.sv @@
package hsvrgb_pkg;

  // Field widths
  localparam int HUE_W  = 16;
  localparam int Q_W    = 13;   // Q1.12 saturation and value
  localparam int CH_W   = 12;   // Q8.4 channel
  localparam int CQ_W   = 25;   // chroma v*s, Q1.24, at most 2^24
  localparam int HW_W   = 15;   // wrapped hue, 0..23039
  localparam int WT_W   = 12;   // component weight, 0..3840
  localparam int T_W    = 36;   // channel sum, at most 2^24 * 3840
  localparam int RND_W  = T_W + 5;

  // Hue geometry in 1/64 degree units
  localparam logic [17:0]     HUE_OFS    = 18'd46080;
  localparam logic [16:0]     HUE_TWO    = 17'd46080;
  localparam logic [HW_W-1:0] HUE_FULL   = 15'd23040;
  localparam logic [HW_W-1:0] HUE_SECTOR = 15'd3840;
  localparam logic [WT_W-1:0] WT_FULL    = 12'd3840;
  localparam logic [Q_W-1:0]  Q_ONE      = 13'd4096;

  // Half of 2^28 for round half up of (T * 17) >> 28
  localparam logic [RND_W-1:0] RND_HALF = RND_W'(64'd134217728);

  // 60 degree sectors
  localparam logic [2:0] SEC_RY = 3'd0;   // red to yellow
  localparam logic [2:0] SEC_YG = 3'd1;   // yellow to green
  localparam logic [2:0] SEC_GC = 3'd2;   // green to cyan
  localparam logic [2:0] SEC_CB = 3'd3;   // cyan to blue
  localparam logic [2:0] SEC_BM = 3'd4;   // blue to magenta
  localparam logic [2:0] SEC_MR = 3'd5;   // magenta to red

  // Stage advance enables shared with the channel lanes
  typedef struct packed {
    logic s3;
    logic s4;
    logic s5;
  } hsvrgb_adv_t;

endpackage

@@ hdl/hsv_to_rgb_converter_core.sv @@
// Channel | Direction | Word contents (lowest bit first)
// in_     | slave     | hue[15:0] signed, saturation[28:16], brightness_value[41:29]
// out_    | master    | red[11:0], green[23:12], blue[35:24]
//
// One word per cycle sustained while the output is not stalled.
// Five register stages: hue wrap and clamp; chroma, offset and sector weights;
// weighted chroma and offset times 3840; offset add; rounding into the output.
// Reset clears only the stage valid bits; payload stages are not reset.
// A stalled result holds; bubbles close up behind it, so input is taken
// until every stage is full.
module hsv_to_rgb_converter_core
  import hsvrgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,    // hue, saturation, brightness_value, zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata    // red, green, blue, zero pad
);

  logic [4:0]         vld_r;
  logic [4:0]         vld_nxt;
  logic [4:0]         en;
  hsvrgb_adv_t        adv;

  logic [HUE_W-1:0]   in_hue;
  logic [Q_W-1:0]     in_sat;
  logic [Q_W-1:0]     in_val;

  logic [17:0]        hue_ofs;
  logic [16:0]        hue_a;
  logic [16:0]        hue_b;
  logic [HW_W-1:0]    hw_r;
  logic [Q_W-1:0]     sat_r;
  logic [Q_W-1:0]     val_r;

  logic [2:0]         sector;
  logic [HW_W-1:0]    pair_base;
  logic [HW_W-1:0]    pos;
  logic [HW_W-1:0]    sec_off;
  logic [WT_W-1:0]    xw;
  logic [WT_W-1:0]    wr;
  logic [WT_W-1:0]    wg;
  logic [WT_W-1:0]    wb;
  logic [2*Q_W-1:0]   cq_full;
  logic [2*Q_W-1:0]   mq_full;
  logic [CQ_W-1:0]    cq_r;
  logic [CQ_W-1:0]    mq_r;
  logic [WT_W-1:0]    wr_r;
  logic [WT_W-1:0]    wg_r;
  logic [WT_W-1:0]    wb_r;

  logic [T_W:0]       m_full;
  logic [T_W-1:0]     m3840_r;

  logic [CH_W-1:0]    red;
  logic [CH_W-1:0]    green;
  logic [CH_W-1:0]    blue;

  assign in_hue = in_tdata[15:0];
  assign in_sat = in_tdata[28:16];
  assign in_val = in_tdata[41:29];

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    en[4] = !vld_r[4] || out_tready;
    for (int i = 3; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  assign in_tready = en[0];
  assign adv.s3    = en[2];
  assign adv.s4    = en[3];
  assign adv.s5    = en[4];

  always_comb begin
    vld_nxt = vld_r;
    if (en[0]) vld_nxt[0] = in_tvalid;
    for (int i = 1; i < 5; i++) begin
      if (en[i]) vld_nxt[i] = vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Stage 1: wrap hue into one turn, clamp saturation and value
  assign hue_ofs = {{2{in_hue[HUE_W-1]}}, in_hue} + HUE_OFS;
  assign hue_a   = (hue_ofs[16:0] >= HUE_TWO) ? hue_ofs[16:0] - HUE_TWO : hue_ofs[16:0];
  assign hue_b   = (hue_a >= {2'b0, HUE_FULL}) ? hue_a - {2'b0, HUE_FULL} : hue_a;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      hw_r  <= hue_b[HW_W-1:0];
      sat_r <= (in_sat > Q_ONE) ? Q_ONE : in_sat;
      val_r <= (in_val > Q_ONE) ? Q_ONE : in_val;
    end
  end

  // Stage 2: chroma, offset, sector and secondary weight
  always_comb begin
    priority if (hw_r >= 15'd19200) sector = SEC_MR;
    else if (hw_r >= 15'd15360)     sector = SEC_BM;
    else if (hw_r >= 15'd11520)     sector = SEC_CB;
    else if (hw_r >= 15'd7680)      sector = SEC_GC;
    else if (hw_r >= HUE_SECTOR)    sector = SEC_YG;
    else                            sector = SEC_RY;
  end

  always_comb begin
    unique case (sector[2:1])
      2'd0:    pair_base = 15'd0;
      2'd1:    pair_base = 15'd7680;
      default: pair_base = 15'd15360;
    endcase
  end

  assign pos     = hw_r - pair_base;
  assign sec_off = (pos >= HUE_SECTOR) ? pos - HUE_SECTOR : HUE_SECTOR - pos;
  assign xw      = WT_FULL - sec_off[WT_W-1:0];

  // Chroma takes the full weight, the secondary the ramp, the third none
  always_comb begin
    unique case (sector)
      SEC_RY:  begin wr = WT_FULL; wg = xw;      wb = '0;      end
      SEC_YG:  begin wr = xw;      wg = WT_FULL; wb = '0;      end
      SEC_GC:  begin wr = '0;      wg = WT_FULL; wb = xw;      end
      SEC_CB:  begin wr = '0;      wg = xw;      wb = WT_FULL; end
      SEC_BM:  begin wr = xw;      wg = '0;      wb = WT_FULL; end
      default: begin wr = WT_FULL; wg = '0;      wb = xw;      end
    endcase
  end

  assign cq_full = val_r * sat_r;
  assign mq_full = val_r * (Q_ONE - sat_r);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      cq_r <= cq_full[CQ_W-1:0];
      mq_r <= mq_full[CQ_W-1:0];
      wr_r <= wr;
      wg_r <= wg;
      wb_r <= wb;
    end
  end

  // Stage 3: offset times 3840 as a shift and subtract
  assign m_full = {mq_r, 12'b0} - {4'b0, mq_r, 8'b0};

  always_ff @(posedge clk) begin
    if (en[2]) begin
      m3840_r <= m_full[T_W-1:0];
    end
  end

  // Stages 3 to 5 of each channel
  hsvrgb_chan u_red (
    .clk   (clk),
    .adv   (adv),
    .cq    (cq_r),
    .wt    (wr_r),
    .m3840 (m3840_r),
    .ch    (red)
  );

  hsvrgb_chan u_green (
    .clk   (clk),
    .adv   (adv),
    .cq    (cq_r),
    .wt    (wg_r),
    .m3840 (m3840_r),
    .ch    (green)
  );

  hsvrgb_chan u_blue (
    .clk   (clk),
    .adv   (adv),
    .cq    (cq_r),
    .wt    (wb_r),
    .m3840 (m3840_r),
    .ch    (blue)
  );

  assign out_tvalid = vld_r[4];
  assign out_tdata  = {4'b0, blue, green, red};

  // A full pipeline facing a stalled sink takes no word
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r == 5'b11111 && !out_tready) |-> !in_tready)
    else $error("input taken while every stage is full and output stalled");

  // Channels never exceed 255.0
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (red <= 12'd4080 && green <= 12'd4080 && blue <= 12'd4080))
    else $error("channel above 4080");

  // An accepted word reaches the first stage on the next edge
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld_r[0])
    else $error("accepted word lost at pipeline entry");

  // Reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

@@ hdl/hsvrgb_chan.sv @@
module hsvrgb_chan
  import hsvrgb_pkg::*;
(
  input  logic              clk,
  input  hsvrgb_adv_t       adv,
  input  logic [CQ_W-1:0]   cq,        // stage 2 chroma
  input  logic [WT_W-1:0]   wt,        // stage 2 weight of this channel
  input  logic [T_W-1:0]    m3840,     // stage 3 offset m * 3840
  output logic [CH_W-1:0]   ch
);

  logic [CQ_W+WT_W-1:0] prod_full;
  logic [T_W-1:0]       prod_r;
  logic [T_W-1:0]       sum_r;
  logic [RND_W-1:0]     rnd;
  logic [CH_W-1:0]      ch_r;

  assign prod_full = cq * wt;

  // Scale the outcome to Q8.4: (T * 17 + 2^27) >> 28
  assign rnd = {5'b0, sum_r} + {1'b0, sum_r, 4'b0} + RND_HALF;

  // Stage 3: weighted chroma
  always_ff @(posedge clk) begin
    if (adv.s3) begin
      prod_r <= prod_full[T_W-1:0];
    end
  end

  // Stage 4: add the offset
  always_ff @(posedge clk) begin
    if (adv.s4) begin
      sum_r <= prod_r + m3840;
    end
  end

  // Stage 5: round into the output word
  always_ff @(posedge clk) begin
    if (adv.s5) begin
      ch_r <= rnd[CH_W+27:28];
    end
  end

  assign ch = ch_r;

endmodule
